[rtl/trb_pkg.sv]
// shared types and codes for the timestamp reorder buffer
`default_nettype none
package trb_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned PayW  = 48;
  localparam int unsigned OccW  = 7;
  localparam int unsigned EntW  = TimeW + PayW;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_EVICT  = 2'd0,
    KIND_POP    = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  // ram read address source
  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,  // front plus eviction index
    RD_BASE = 2'd1,  // first entry kept after eviction
    RD_SCAN = 2'd2   // entry just below the scan slot
  } rd_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CHECK,
    ST_EVICT_RD,
    ST_EVICT_OUT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_RESULT
  } state_e;

  // input word
  typedef struct packed {
    cmd_e              cmd;
    logic [TimeW-1:0]  new_time;
    logic [PayW-1:0]   new_payload;
  } in_word_t;

  // output word
  typedef struct packed {
    kind_e             kind;
    logic [TimeW-1:0]  item_time;
    logic [PayW-1:0]   item_payload;
    logic              late_error;
    logic [OccW-1:0]   occupancy;
    logic              last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;     // capture input word
    logic       rd_en;       // issue ram read
    rd_sel_e    rd_sel;
    logic       idx_inc;     // next eviction
    logic       pos_load;    // scan slot starts above the newest kept entry
    logic       pos_dec;     // scan slot moves down one
    logic       late_cap;    // compare new time against read front time
    logic       wr_shift;    // write read data one slot up
    logic       wr_new;      // write new item at scan slot
    logic       commit;      // update front, fill and eviction flag
    logic       out_load;
    kind_e      out_kind;
    logic       out_entry;   // take time/payload from ram read data
    logic       out_late;
    logic       out_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic cmd;
    logic empty;
    logic chk_need;    // late check needed for this insert
    logic evict_any;   // list is full, evictions pending
    logic evict_last;  // current eviction is the final one
    logic late;        // captured late flag
    logic pos_zero;    // scan slot at the front
    logic rd_gt;       // read entry time greater than new time
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

[rtl/trb_if.sv]
// valid/ready channel carrying one word
`default_nettype none
interface trb_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/trb_ram.sv]
// generic single port write, single read ram with registered read
`default_nettype none
module trb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

[rtl/trb_ctrl.sv]
// controller state machine sequencing evict, pop and insert
`default_nettype none
module trb_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire trb_pkg::sts_t sts_i,
  output trb_pkg::ctl_t    ctl_o
);
  trb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    ctl_o.out_kind = trb_pkg::KIND_STATUS;
    ctl_o.rd_sel   = trb_pkg::RD_HEAD;
    in_ready_o = 1'b0;
    case (state_q)
      trb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d = trb_pkg::ST_DISPATCH;
        end
      end
      trb_pkg::ST_DISPATCH: begin
        if (sts_i.cmd == trb_pkg::CMD_POP) begin
          // read the oldest entry unless nothing is held
          ctl_o.rd_en  = !sts_i.empty;
          ctl_o.rd_sel = trb_pkg::RD_HEAD;
          state_d = trb_pkg::ST_RESULT;
        end else begin
          ctl_o.pos_load = 1'b1;
          if (sts_i.chk_need) begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_sel = trb_pkg::RD_BASE;
            state_d = trb_pkg::ST_CHECK;
          end else if (sts_i.evict_any) begin
            state_d = trb_pkg::ST_EVICT_RD;
          end else begin
            state_d = trb_pkg::ST_SCAN_RD;
          end
        end
      end
      trb_pkg::ST_CHECK: begin
        // late flag is known before any result leaves
        ctl_o.late_cap = 1'b1;
        if (sts_i.evict_any) begin
          state_d = trb_pkg::ST_EVICT_RD;
        end else begin
          state_d = trb_pkg::ST_SCAN_RD;
        end
      end
      trb_pkg::ST_EVICT_RD: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = trb_pkg::RD_HEAD;
        state_d = trb_pkg::ST_EVICT_OUT;
      end
      trb_pkg::ST_EVICT_OUT: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load  = 1'b1;
          ctl_o.out_kind  = trb_pkg::KIND_EVICT;
          ctl_o.out_entry = 1'b1;
          ctl_o.idx_inc   = 1'b1;
          if (sts_i.evict_last) begin
            state_d = trb_pkg::ST_SCAN_RD;
          end else begin
            state_d = trb_pkg::ST_EVICT_RD;
          end
        end
      end
      trb_pkg::ST_SCAN_RD: begin
        if (sts_i.late) begin
          state_d = trb_pkg::ST_RESULT;
        end else if (sts_i.pos_zero) begin
          ctl_o.wr_new = 1'b1;
          state_d = trb_pkg::ST_RESULT;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = trb_pkg::RD_SCAN;
          state_d = trb_pkg::ST_SCAN_CMP;
        end
      end
      trb_pkg::ST_SCAN_CMP: begin
        if (sts_i.rd_gt) begin
          ctl_o.wr_shift = 1'b1;
          ctl_o.pos_dec  = 1'b1;
          state_d = trb_pkg::ST_SCAN_RD;
        end else begin
          ctl_o.wr_new = 1'b1;
          state_d = trb_pkg::ST_RESULT;
        end
      end
      trb_pkg::ST_RESULT: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_last = 1'b1;
          ctl_o.commit   = 1'b1;
          if (sts_i.cmd == trb_pkg::CMD_POP) begin
            if (sts_i.empty) begin
              ctl_o.out_kind = trb_pkg::KIND_EMPTY;
            end else begin
              ctl_o.out_kind  = trb_pkg::KIND_POP;
              ctl_o.out_entry = 1'b1;
            end
          end else begin
            ctl_o.out_kind = trb_pkg::KIND_STATUS;
            ctl_o.out_late = sts_i.late;
          end
          state_d = trb_pkg::ST_IDLE;
        end
      end
      default: state_d = trb_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/trb_dp.sv]
// datapath: circular entry store, front pointer, fill count, output register
`default_nettype none
module trb_dp #(
  parameter int unsigned BufferDepth = 64,
  parameter int unsigned EvictCount  = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_cmd_i,
  input  wire logic [trb_pkg::TimeW-1:0]   in_time_i,
  input  wire logic [trb_pkg::PayW-1:0]    in_payload_i,
  input  wire trb_pkg::ctl_t               ctl_i,
  output trb_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       out_kind_o,
  output logic [trb_pkg::TimeW-1:0]        out_time_o,
  output logic [trb_pkg::PayW-1:0]         out_payload_o,
  output logic                             out_late_o,
  output logic [trb_pkg::OccW-1:0]         out_occ_o,
  output logic                             out_last_o
);
  localparam int unsigned AW = $clog2(BufferDepth);
  localparam int unsigned CW = $clog2(BufferDepth + 1);
  // a full list holds BufferDepth entries, so eviction removes at most that many
  localparam int unsigned EvictN = (EvictCount < BufferDepth) ? EvictCount : BufferDepth;

  logic                      cmd_q;
  logic [trb_pkg::TimeW-1:0] time_q;
  logic [trb_pkg::PayW-1:0]  pay_q;
  logic [AW-1:0]             front_q;
  logic [CW-1:0]             fill_q;
  logic [CW-1:0]             idx_q;
  logic [CW-1:0]             pos_q;
  logic                      evicted_q;
  logic                      late_q;
  logic                      full;
  logic                      evicted_next;
  logic [CW-1:0]             evict_n;
  logic [CW-1:0]             rem;
  logic [CW-1:0]             occ_fin;
  logic [AW-1:0]             base;
  logic [AW-1:0]             front_fin;
  logic [AW-1:0]             raddr, waddr;
  logic                      we;
  logic [trb_pkg::EntW-1:0]  wdata, rdata;
  logic [trb_pkg::TimeW-1:0] rd_time;

  // list after the eviction of this step
  assign full         = (fill_q >= CW'(BufferDepth));
  assign evict_n      = full ? CW'(EvictN) : '0;
  assign rem          = fill_q - evict_n;
  assign base         = front_q + AW'(evict_n);
  assign evicted_next = evicted_q | full;

  // occupancy and front at the end of the step
  always_comb begin
    if (cmd_q == trb_pkg::CMD_POP) begin
      if (fill_q == '0) begin
        occ_fin   = '0;
        front_fin = front_q;
      end else begin
        occ_fin   = fill_q - CW'(1);
        front_fin = front_q + AW'(1);
      end
    end else begin
      occ_fin   = rem + CW'(!late_q);
      front_fin = base;
    end
  end

  // read address
  always_comb begin
    case (ctl_i.rd_sel)
      trb_pkg::RD_HEAD: raddr = front_q + AW'(idx_q);
      trb_pkg::RD_SCAN: raddr = base + AW'(pos_q - CW'(1));
      default:          raddr = base;
    endcase
  end

  assign rd_time = rdata[trb_pkg::EntW-1 -: trb_pkg::TimeW];
  assign we      = ctl_i.wr_shift | ctl_i.wr_new;
  assign waddr   = base + AW'(pos_q);
  assign wdata   = ctl_i.wr_shift ? rdata : {time_q, pay_q};

  trb_ram #(.Width(trb_pkg::EntW), .Depth(1 << AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // captured word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q  <= in_cmd_i;
      time_q <= in_time_i;
      pay_q  <= in_payload_i;
    end
  end

  // pointers, counts and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      fill_q    <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      evicted_q <= 1'b0;
      late_q    <= 1'b0;
    end else begin
      if (ctl_i.load_in) begin
        idx_q <= '0;
      end else if (ctl_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (ctl_i.pos_load) begin
        pos_q <= rem;
      end else if (ctl_i.pos_dec) begin
        pos_q <= pos_q - CW'(1);
      end
      if (ctl_i.load_in) begin
        late_q <= 1'b0;
      end else if (ctl_i.late_cap) begin
        late_q <= (time_q < rd_time);
      end
      if (ctl_i.commit) begin
        front_q <= front_fin;
        fill_q  <= occ_fin;
        if (cmd_q == trb_pkg::CMD_INSERT) begin
          evicted_q <= evicted_next;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_kind_o    <= ctl_i.out_kind;
      out_time_o    <= ctl_i.out_entry ? rd_time : '0;
      out_payload_o <= ctl_i.out_entry ? rdata[trb_pkg::PayW-1:0] : '0;
      out_late_o    <= ctl_i.out_late;
      out_last_o    <= ctl_i.out_last;
      out_occ_o     <= trb_pkg::OccW'(occ_fin);
    end
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.empty      = (fill_q == '0);
  assign sts_o.chk_need   = evicted_next && (rem != '0);
  assign sts_o.evict_any  = (evict_n != '0);
  assign sts_o.evict_last = (idx_q >= evict_n - CW'(1));
  assign sts_o.late       = late_q;
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.rd_gt      = (rd_time > time_q);
  assign sts_o.out_busy   = out_valid_o && !out_ready_i;
endmodule
`default_nettype wire

[rtl/timestamp_reorder_buffer.sv]
// top level of the timestamp reorder buffer
//  channel | dir | payload
//  in_ch   | in  | cmd, new_time, new_payload
//  out_ch  | out | kind, item_time, item_payload, late_error, occupancy, last
// one word in flight: input is taken only while the controller is idle
// a pop dispatches and then gives its result; an insert dispatches, does the late check once
// an eviction has happened, reads and sends each evicted entry, reads and shifts up each later
// entry, writes the new item and gives its status; a late item skips the scan after any evictions
// the entry ram has a single registered read port
// output stalls hold the controller; reset clears counts, entries are read only once written
`default_nettype none
module timestamp_reorder_buffer #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned EVICT_COUNT  = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  trb_if.sink      in_ch,
  trb_if.source    out_ch
);
  trb_pkg::ctl_t ctl;
  trb_pkg::sts_t sts;
  logic [1:0] kind;

  trb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  trb_dp #(.BufferDepth(BUFFER_DEPTH), .EvictCount(EVICT_COUNT)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_cmd_i      (in_ch.data.cmd),
    .in_time_i     (in_ch.data.new_time),
    .in_payload_i  (in_ch.data.new_payload),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_kind_o    (kind),
    .out_time_o    (out_ch.data.item_time),
    .out_payload_o (out_ch.data.item_payload),
    .out_late_o    (out_ch.data.late_error),
    .out_occ_o     (out_ch.data.occupancy),
    .out_last_o    (out_ch.data.last)
  );
  assign out_ch.data.kind = trb_pkg::kind_e'(kind);
endmodule
`default_nettype wire

[rtl/trb_checker.sv]
// port level checks for the timestamp reorder buffer
`default_nettype none
module trb_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last,
  input wire logic [1:0] out_kind
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("output word dropped");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("second word taken while busy");
  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == trb_pkg::KIND_EVICT |-> !out_last)
    else $error("eviction marked last");
endmodule

bind timestamp_reorder_buffer trb_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last), .out_kind(out_ch.data.kind)
);
`default_nettype wire

[verif/tb_timestamp_reorder_buffer.sv]
// testbench for the timestamp reorder buffer: directed and random traffic against a sorted-list predictor
`default_nettype none
module tb_timestamp_reorder_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 64;
  localparam int unsigned Evict = 16;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned TimeW = trb_pkg::TimeW;
  localparam int unsigned PayW  = trb_pkg::PayW;
  localparam int unsigned OccW  = trb_pkg::OccW;
  localparam int LongHoldAt = 120;

  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [PayW-1:0]  p;
  } frag_t;

  // one pending word, or a marker that holds the sender until all results are in
  typedef struct {
    trb_pkg::in_word_t w;
    bit                drain;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  trb_if #(.T(trb_pkg::in_word_t))  in_ch ();
  trb_if #(.T(trb_pkg::out_word_t)) out_ch ();

  timestamp_reorder_buffer #(
    .BUFFER_DEPTH(Depth),
    .EVICT_COUNT (Evict)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk_i = ~clk_i;

  pend_t              pending_q[$];
  trb_pkg::out_word_t expected_q[$];
  frag_t              sorted_list[$];
  bit                 list_evicted;
  int                 errors;
  bit                 quiet_mode;

  task automatic report(input string what, input trb_pkg::out_word_t got,
                        input trb_pkg::out_word_t exp_w);
    errors++;
    $display("error %s: got kind %0d t %0h p %0h late %0b occ %0d last %0b, %s",
             what, got.kind, got.item_time, got.item_payload, got.late_error,
             got.occupancy, got.last,
             $sformatf("exp kind %0d t %0h p %0h late %0b occ %0d last %0b",
                       exp_w.kind, exp_w.item_time, exp_w.item_payload,
                       exp_w.late_error, exp_w.occupancy, exp_w.last));
  endtask

  // predict the results of one accepted word and queue them
  function automatic void predict_list_step(input trb_pkg::in_word_t w);
    trb_pkg::out_word_t res[$];
    trb_pkg::out_word_t r;
    frag_t              f;
    int                 pos;
    bit                 late;
    late = 1'b0;
    if (w.cmd == trb_pkg::CMD_POP) begin
      r = '0;
      if (sorted_list.size() == 0) begin
        r.kind = trb_pkg::KIND_EMPTY;
      end else begin
        f = sorted_list.pop_front();
        r.kind = trb_pkg::KIND_POP;
        r.item_time = f.t;
        r.item_payload = f.p;
      end
      res.push_back(r);
    end else begin
      if (sorted_list.size() >= Depth) begin
        for (int i = 0; i < Evict && sorted_list.size() > 0; i++) begin
          f = sorted_list.pop_front();
          r = '0;
          r.kind = trb_pkg::KIND_EVICT;
          r.item_time = f.t;
          r.item_payload = f.p;
          res.push_back(r);
        end
        list_evicted = 1'b1;
      end
      if (list_evicted && sorted_list.size() > 0 && w.new_time < sorted_list[0].t) begin
        late = 1'b1;
      end else if (sorted_list.size() < Depth) begin
        pos = sorted_list.size();
        while (pos > 0 && sorted_list[pos-1].t > w.new_time) pos--;
        f.t = w.new_time;
        f.p = w.new_payload;
        sorted_list.insert(pos, f);
      end
      r = '0;
      r.kind = trb_pkg::KIND_STATUS;
      r.late_error = late;
      res.push_back(r);
    end
    foreach (res[k]) begin
      res[k].occupancy = OccW'(sorted_list.size());
      res[k].last = (k == res.size() - 1);
      expected_q.push_back(res[k]);
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_mode || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int gap_cnt;
  int in_count;
  always @(posedge clk_i) begin
    pend_t nxt;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      gap_cnt = 0;
      in_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_list_step(in_ch.data);
        in_count++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0 && pending_q[0].drain) begin
          in_ch.valid <= 1'b0;
          if (expected_q.size() == 0) void'(pending_q.pop_front());
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.data <= nxt.w;
          gap_cnt = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    trb_pkg::out_word_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", out_ch.data, '0);
      end else begin
        exp_w = expected_q.pop_front();
        if (out_ch.data.kind != exp_w.kind) report("kind", out_ch.data, exp_w);
        else if (out_ch.data.item_time != exp_w.item_time)
          report("item_time", out_ch.data, exp_w);
        else if (out_ch.data.item_payload != exp_w.item_payload)
          report("item_payload", out_ch.data, exp_w);
        else if (out_ch.data.late_error != exp_w.late_error)
          report("late_error", out_ch.data, exp_w);
        else if (out_ch.data.occupancy != exp_w.occupancy)
          report("occupancy", out_ch.data, exp_w);
        else if (out_ch.data.last != exp_w.last) report("last", out_ch.data, exp_w);
      end
    end
  end

  // receiver stalls, with one long hold-off while the sender keeps offering
  int  stall_cnt;
  bit  long_done;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt = 0;
      long_done = 1'b0;
    end else begin
      if (!long_done && in_count >= LongHoldAt) begin
        stall_cnt = 300;
        long_done = 1'b1;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        if (!out_ch.ready && $urandom_range(0, 99) < 8) stall_cnt = pick_gap();
        out_ch.ready <= (quiet_mode || $urandom_range(0, 99) < 75);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  int idle_cnt;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("timestamp_reorder_buffer: mismatch");
        $finish;
      end
    end
  end

  task automatic add_word(input trb_pkg::cmd_e c, input logic [TimeW-1:0] t,
                          input logic [PayW-1:0] p);
    pend_t e;
    e.w.cmd = c;
    e.w.new_time = t;
    e.w.new_payload = p;
    e.drain = 1'b0;
    pending_q.push_back(e);
  endtask

  task automatic add_drain();
    pend_t e;
    e.w = '0;
    e.drain = 1'b1;
    pending_q.push_back(e);
  endtask

  function automatic logic [PayW-1:0] rand_payload();
    return PayW'({$urandom(), $urandom()});
  endfunction

  // stimulus and end of run
  initial begin
    logic [TimeW-1:0] base;
    logic [TimeW-1:0] t;
    int roll;
    errors = 0;
    list_evicted = 1'b0;
    quiet_mode = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;

    // directed: empty pop, extreme fields, equal times keep arrival order
    add_word(trb_pkg::CMD_POP, '1, '1);
    add_word(trb_pkg::CMD_INSERT, '1, '1);
    add_word(trb_pkg::CMD_INSERT, '0, '0);
    add_word(trb_pkg::CMD_INSERT, {1'b1, {31{2'b01}}}, {24{2'b10}});
    add_word(trb_pkg::CMD_INSERT, {1'b0, {31{2'b10}}}, {24{2'b01}});
    for (int i = 0; i < 3; i++) add_word(trb_pkg::CMD_INSERT, 63'd500, PayW'(i + 1));
    add_word(trb_pkg::CMD_INSERT, 63'd499, 48'habc);
    for (int i = 0; i < 10; i++) add_word(trb_pkg::CMD_POP, '0, '0);
    add_drain();

    // random: mostly rising times with jitter, some stale items, some pops
    base = TimeW'({$urandom_range(0, 255), $urandom()}) + 63'd100000;
    for (int i = 0; i < 260; i++) begin
      if (i % 60 == 0) quiet_mode = 1'b0;
      roll = $urandom_range(0, 99);
      base = base + TimeW'($urandom_range(0, 20));
      if (roll < 12) begin
        add_word(trb_pkg::CMD_POP, TimeW'({$urandom(), $urandom()}), rand_payload());
      end else begin
        if (roll < 22) t = base - TimeW'($urandom_range(0, 3000));
        else t = base + TimeW'($urandom_range(0, 200)) - 63'd100;
        add_word(trb_pkg::CMD_INSERT, t, rand_payload());
      end
      if (i == 150) add_drain();
    end

    // empty the list, then an old time must not count as late
    add_drain();
    for (int i = 0; i < 66; i++) add_word(trb_pkg::CMD_POP, '0, '0);
    add_word(trb_pkg::CMD_INSERT, '0, 48'h5);
    add_word(trb_pkg::CMD_POP, '0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) quiet_mode = ~quiet_mode;
      if (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0) break;
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("timestamp_reorder_buffer: match");
    end else begin
      $display("timestamp_reorder_buffer: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
